@@ design/get_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_pkg
// Shared types and constants of the Gabriel edge test unit.
// ----------------------------------------------------------------------------
package get_pkg;

   // request field widths
   localparam int INDEX_W   = 10;
   localparam int COORD_W   = 16;
   localparam int COUNT_W   = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // csr port
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 11;
   localparam int NUM_POINTS_W  = 11;
   localparam int TOLERANCE_W   = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_POINTS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE  = 1'b1;

   // request command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REJECT = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [INDEX_W-1:0] index_a;
      logic [INDEX_W-1:0] index_b;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
   } entry_type;

   typedef struct packed {
      logic [NUM_POINTS_W-1:0] num_points;
      logic [TOLERANCE_W-1:0]  tolerance;
   } cfg_type;

endpackage

@@ design/gabriel_edge_test_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gabriel_edge_test_unit
// Counts table points strictly inside the diametral circle of a point pair.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: cmd 0 writes point (coord_x, coord_y) at index_a; cmd 1
//   tests the pair index_a, index_b. A word moves when req_valid is high and
//   req_stall low. Loads give no rsp_ word; every test gives exactly one.
//   csr_ channel: index 0 num_points, index 1 tolerance; csr_ready is always
//   high. Write only while the unit is idle.
//   A four entry queue sits between the accepting front and the scanning
//   back, so requests keep being taken while a scan runs.
//   A load writes its point into the table. A test scans the table one
//   point a cycle through the single memory read port, over num_points
//   points capped at MAX_POINTS; the next test starts only after the
//   previous one has been answered. A pair that is equal or out of range
//   is not scanned and is answered with is_edge 0.
//   rsp_ words sit in an output register; a stalled rsp_ holds its word and
//   the back waits, the queue fills, then req_stall rises.
//   Reset clears the csr registers, the queue and the control state; the
//   point table keeps whatever it held and must be loaded before use.
// ----------------------------------------------------------------------------
module gabriel_edge_test_unit
   import get_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [INDEX_W-1:0]     req_index_a,
   input  logic [INDEX_W-1:0]     req_index_b,
   input  logic [COORD_W-1:0]     req_coord_x,
   input  logic [COORD_W-1:0]     req_coord_y,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_edge,
   output logic [COUNT_W-1:0]     rsp_inside_count
);

   logic      push, pop, empty, full;
   entry_type push_entry, head;
   cfg_type   cfg;

   get_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_index_a (req_index_a),
      .req_index_b (req_index_b),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .queue_full  (full),
      .push        (push),
      .push_entry  (push_entry),
      .cfg         (cfg)
   );

   get_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   get_back #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_is_edge      (rsp_is_edge),
      .rsp_inside_count (rsp_inside_count)
   );

endmodule

@@ design/get_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_front
// Holds the csr registers, accepts request words and sorts them into loads,
// queries worth scanning and queries to be answered with no edge.
// ----------------------------------------------------------------------------
module get_front
   import get_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [INDEX_W-1:0]     req_index_a,
   input  logic [INDEX_W-1:0]     req_index_b,
   input  logic [COORD_W-1:0]     req_coord_x,
   input  logic [COORD_W-1:0]     req_coord_y,
   input  logic                   queue_full,
   output logic                   push,
   output entry_type              push_entry,
   output cfg_type                cfg
);

   localparam int NW = ($clog2(MAX_POINTS + 1) > NUM_POINTS_W) ?
                       $clog2(MAX_POINTS + 1) : NUM_POINTS_W;

   logic [NUM_POINTS_W-1:0] num_points_ff, num_points_in;
   logic [TOLERANCE_W-1:0]  tolerance_ff, tolerance_in;
   logic [NW-1:0]           eff_n;
   logic [NW-1:0]           ia_ext, ib_ext;
   logic                    accept;
   logic                    bad_pair;

   assign csr_ready = 1'b1;

   always_comb begin
      num_points_in = num_points_ff;
      tolerance_in  = tolerance_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_POINTS: num_points_in = csr_data[NUM_POINTS_W-1:0];
            CSR_TOLERANCE:  tolerance_in  = csr_data[TOLERANCE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= '0;
         tolerance_ff  <= '0;
      end else begin
         num_points_ff <= num_points_in;
         tolerance_ff  <= tolerance_in;
      end
   end

   assign cfg.num_points = num_points_ff;
   assign cfg.tolerance  = tolerance_ff;

   assign eff_n = (NW'(num_points_ff) < NW'(MAX_POINTS)) ? NW'(num_points_ff)
                                                          : NW'(MAX_POINTS);
   assign ia_ext = NW'(req_index_a);
   assign ib_ext = NW'(req_index_b);

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign bad_pair  = (req_index_a == req_index_b) || (ia_ext >= eff_n) ||
                      (ib_ext >= eff_n);

   always_comb begin
      push_entry.index_a = req_index_a;
      push_entry.index_b = req_index_b;
      push_entry.coord_x = req_coord_x;
      push_entry.coord_y = req_coord_y;
      push_entry.op      = OP_LOAD;
      push               = 1'b0;
      unique case (req_cmd)
         CMD_LOAD: begin
            // loads past the table are dropped here
            push = accept && (ia_ext < NW'(MAX_POINTS));
         end
         CMD_TEST: begin
            push_entry.op = bad_pair ? OP_REJECT : OP_QUERY;
            push          = accept;
         end
         default: ;
      endcase
   end

endmodule

@@ design/get_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module get_queue
   import get_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/get_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// get_back
// Owns the point tables. Writes loads, and for a query fetches both end
// points, then streams every point through a four stage compare pipeline.
// ----------------------------------------------------------------------------
module get_back
   import get_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  entry_type          head,
   input  logic               empty,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_is_edge,
   output logic [COUNT_W-1:0] rsp_inside_count
);

   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW  = ($clog2(MAX_POINTS + 1) > NUM_POINTS_W) ?
                        $clog2(MAX_POINTS + 1) : NUM_POINTS_W;
   localparam int CW  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int DW  = CW + 2;
   localparam int SQW = 2 * DW;
   localparam int SW  = SQW + 1;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_FETCH_I = 6'b000010,
      ST_FETCH_J = 6'b000100,
      ST_SETUP   = 6'b001000,
      ST_SCAN    = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] x_mem [MAX_POINTS];
   logic [CW-1:0] y_mem [MAX_POINTS];
   logic [CW-1:0] rdx_ff, rdy_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   logic [INDEX_W-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [NW-1:0]      k_ff, k_in, count_ff, count_in, eff_n;
   logic signed [DW-1:0] xi_ff, xi_in, yi_ff, yi_in;
   logic signed [DW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [DW-1:0] xk, yk;

   // compare pipeline
   logic                 v1_ff, v1_in, skip1_ff, skip1_in;
   logic                 v2_ff, v2_in, tag2_ff, tag2_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic                 v3_ff, tag3_ff;
   logic [SQW-1:0]       sqx_ff, sqy_ff;
   logic signed [SQW-1:0] prod_x, prod_y;
   logic [SW-1:0]        offset_sq, r2_ff, r2_in;

   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 is_edge_ff, is_edge_in;
   logic [COUNT_W-1:0]   inside_ff, inside_in;

   assign eff_n = (NW'(cfg.num_points) < NW'(MAX_POINTS)) ? NW'(cfg.num_points)
                                                           : NW'(MAX_POINTS);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign xk = DW'($signed(rdx_ff));
   assign yk = DW'($signed(rdy_ff));

   // ---- table ----
   always_ff @(posedge clock) begin
      if (mem_we) begin
         x_mem[AW'(head.index_a)] <= head.coord_x[CW-1:0];
         y_mem[AW'(head.index_a)] <= head.coord_y[CW-1:0];
      end
      rdx_ff <= x_mem[rd_addr];
      rdy_ff <= y_mem[rd_addr];
   end

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = AW'(k_ff);
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      k_in         = k_ff;
      v1_in        = 1'b0;
      skip1_in     = (k_ff == NW'(ia_ff)) || (k_ff == NW'(ib_ff));
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      is_edge_in   = is_edge_ff;
      inside_in    = inside_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               case (head.op)
                  OP_LOAD: begin
                     pop    = 1'b1;
                     mem_we = 1'b1;
                  end
                  OP_QUERY: begin
                     pop      = 1'b1;
                     ia_in    = head.index_a;
                     ib_in    = head.index_b;
                     state_in = ST_FETCH_I;
                  end
                  default: begin
                     // rejected pair: answer with no edge
                     if (out_free) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        is_edge_in   = 1'b0;
                        inside_in    = '0;
                     end
                  end
               endcase
            end
         end
         ST_FETCH_I: begin
            rd_addr  = AW'(ia_ff);
            state_in = ST_FETCH_J;
         end
         ST_FETCH_J: begin
            rd_addr  = AW'(ib_ff);
            xi_in    = xk;
            yi_in    = yk;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            sx_in    = xi_ff + xk;
            sy_in    = yi_ff + yk;
            k_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (k_ff < eff_n) begin
               v1_in = 1'b1;
               k_in  = k_ff + 1'b1;
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               is_edge_in   = (count_ff <= NW'(cfg.tolerance));
               inside_in    = (count_ff > NW'(COUNT_MAX)) ? COUNT_MAX
                                                          : count_ff[COUNT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- compare pipeline ----
   // the setup slot sends the diameter through the same squarers to form r2
   always_comb begin
      tag2_in = (state_ff == ST_SETUP);
      v2_in   = (v1_ff && !skip1_ff) || tag2_in;
      if (tag2_in) begin
         dx_in = xi_ff - xk;
         dy_in = yi_ff - yk;
      end else begin
         dx_in = (xk <<< 1) - sx_ff;
         dy_in = (yk <<< 1) - sy_ff;
      end
   end

   assign prod_x    = dx_ff * dx_ff;
   assign prod_y    = dy_ff * dy_ff;
   assign offset_sq = SW'(sqx_ff) + SW'(sqy_ff);

   always_comb begin
      r2_in    = r2_ff;
      count_in = count_ff;
      if (state_ff == ST_SETUP) begin
         count_in = '0;
      end else if (v3_ff) begin
         if (tag3_ff) begin
            r2_in = offset_sq;
         end else if (offset_sq < r2_ff) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff     <= ia_in;
      ib_ff     <= ib_in;
      xi_ff     <= xi_in;
      yi_ff     <= yi_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      k_ff      <= k_in;
      count_ff  <= count_in;
      skip1_ff  <= skip1_in;
      tag2_ff   <= tag2_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      tag3_ff   <= tag2_ff;
      sqx_ff    <= $unsigned(prod_x);
      sqy_ff    <= $unsigned(prod_y);
      r2_ff     <= r2_in;
      is_edge_ff <= is_edge_in;
      inside_ff <= inside_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_edge      = is_edge_ff;
   assign rsp_inside_count = inside_ff;

endmodule
